// File: rtl/core/etpbm_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the event to port bit mapper
package etpbm_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EVENT  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_INSERT,
    S_PORT,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] device;
    logic        inverted;
    logic [2:0]  port_index;
    logic [7:0]  clear_mask;
    logic [7:0]  set_mask;
    logic        active;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] touched_port;
    logic [7:0] port_value;
  } rsp_t;

  // mapping payload carried along the cell row next to its key
  typedef struct packed {
    logic       inverted;
    logic [2:0] port;
    logic [7:0] clr_mask;
    logic [7:0] set_mask;
  } attr_t;

  typedef struct packed {
    logic drop;
    logic insert;
  } cell_cmd_t;

endpackage

// File: rtl/core/event_to_port_bit_mapper.sv
`timescale 1ns / 1ps
// top level: request sequencer, cell row holding the sorted mappings, port bytes
//
// Mappings live in a row of TABLE_DEPTH cells kept sorted by device id; every
// cell compares its key with the request at once, and add or remove moves the
// tail of the row one place per cycle through neighbor handoff. A request is
// taken when start is high and busy is low. After acceptance comes lookup,
// then the response state for remove, event misses and unused opcodes, and
// first the insert or port state for add and event hits (a second row pass
// for the insert, or a port byte read-modify-write). The result is on rsp
// while done is high, for a single cycle, and must be taken then; busy drops
// in the following cycle. No clearing pass after reset.
module event_to_port_bit_mapper #(
  parameter int TABLE_DEPTH = 32,
  parameter int PORT_COUNT  = 8,
  parameter int DEVICE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  etpbm_pkg::req_t   req,
  output logic              busy,
  output logic              done,
  output etpbm_pkg::rsp_t   rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  etpbm_pkg::state_t    state, state_next;
  etpbm_pkg::req_t      req_q;
  etpbm_pkg::rsp_t      rsp_q;
  etpbm_pkg::attr_t     hit_attr;
  etpbm_pkg::attr_t     new_attr;
  etpbm_pkg::attr_t     sel_attr;
  etpbm_pkg::cell_cmd_t cmd;
  logic [DEVICE_BITS-1:0] key;
  logic [DEVICE_BITS-1:0] key_in;
  logic [DEVICE_BITS+15:0] dev_wide;
  logic [CW-1:0]          count;
  logic [7:0]             ports [PORT_COUNT];

  logic [DEVICE_BITS-1:0] dev_q   [TABLE_DEPTH];
  etpbm_pkg::attr_t       attr_q  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] slot_vec;

  logic                   any_hit;
  logic                   full;
  logic                   is_add;
  logic                   is_remove;
  logic                   is_event;
  logic [PW+2:0]          port_wide;
  logic [PW-1:0]          pidx;
  logic                   port_ok;
  logic [7:0]             pval;

  always_comb begin
    dev_wide = {{DEVICE_BITS{1'b0}}, req.device};
    key_in   = dev_wide[DEVICE_BITS-1:0];
    new_attr = '{inverted: req_q.inverted, port: req_q.port_index,
                 clr_mask: req_q.clear_mask, set_mask: req_q.set_mask};
    any_hit   = |hit_vec;
    full      = count == CW'(TABLE_DEPTH);
    is_add    = req_q.opcode == etpbm_pkg::OP_ADD;
    is_remove = req_q.opcode == etpbm_pkg::OP_REMOVE;
    is_event  = req_q.opcode == etpbm_pkg::OP_EVENT;
    cmd.drop   = (state == etpbm_pkg::S_LOOKUP) && any_hit && (is_add || is_remove);
    cmd.insert = (state == etpbm_pkg::S_INSERT) && !full;
  end

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [DEVICE_BITS-1:0] l_dev, r_dev;
    etpbm_pkg::attr_t       l_attr, r_attr;
    logic                   l_slot;

    if (i == 0) begin : g_first
      assign l_dev  = key;
      assign l_attr = new_attr;
      assign l_slot = 1'b0;
    end else begin : g_mid
      assign l_dev  = dev_q[i-1];
      assign l_attr = attr_q[i-1];
      assign l_slot = slot_vec[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign r_dev  = dev_q[i];
      assign r_attr = attr_q[i];
    end else begin : g_inner
      assign r_dev  = dev_q[i+1];
      assign r_attr = attr_q[i+1];
    end

    etpbm_cell #(
      .IDX         (i),
      .DEVICE_BITS (DEVICE_BITS),
      .CW          (CW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .key        (key),
      .new_attr   (new_attr),
      .count      (count),
      .left_dev   (l_dev),
      .left_attr  (l_attr),
      .left_slot  (l_slot),
      .right_dev  (r_dev),
      .right_attr (r_attr),
      .dev        (dev_q[i]),
      .attr       (attr_q[i]),
      .hit        (hit_vec[i]),
      .slot       (slot_vec[i])
    );
  end

  // at most one cell hits, so an or of gated entries selects it
  always_comb begin
    sel_attr = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_vec[i]) begin
        sel_attr = etpbm_pkg::attr_t'(sel_attr | attr_q[i]);
      end
    end
  end

  // port byte update
  always_comb begin
    port_wide = {{PW{1'b0}}, hit_attr.port};
    pidx      = port_wide[PW-1:0];
    port_ok   = port_wide < (PW+3)'(PORT_COUNT);
    pval      = ports[pidx] & ~hit_attr.clr_mask;
    if (req_q.active != hit_attr.inverted) begin
      pval = pval | hit_attr.set_mask;
    end
    if (!port_ok) begin
      pval = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      etpbm_pkg::S_IDLE: begin
        if (start) state_next = etpbm_pkg::S_LOOKUP;
      end
      etpbm_pkg::S_LOOKUP: begin
        if (is_add) begin
          state_next = etpbm_pkg::S_INSERT;
        end else if (is_event && any_hit) begin
          state_next = etpbm_pkg::S_PORT;
        end else begin
          state_next = etpbm_pkg::S_RESP;
        end
      end
      etpbm_pkg::S_INSERT: state_next = etpbm_pkg::S_RESP;
      etpbm_pkg::S_PORT:   state_next = etpbm_pkg::S_RESP;
      etpbm_pkg::S_RESP:   state_next = etpbm_pkg::S_IDLE;
      default:             state_next = etpbm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = state != etpbm_pkg::S_IDLE;
    done = state == etpbm_pkg::S_RESP;
    rsp  = rsp_q;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etpbm_pkg::S_IDLE;
      count <= '0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        ports[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cmd.drop) begin
        count <= count - CW'(1);
      end else if (cmd.insert) begin
        count <= count + CW'(1);
      end
      if (state == etpbm_pkg::S_PORT && port_ok) begin
        ports[pidx] <= pval;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    case (state)
      etpbm_pkg::S_IDLE: begin
        if (start) begin
          req_q <= req;
          key   <= key_in;
        end
      end
      etpbm_pkg::S_LOOKUP: begin
        hit_attr           <= sel_attr;
        rsp_q.touched_port <= '0;
        rsp_q.port_value   <= '0;
        rsp_q.status       <= ((is_remove || is_event) && !any_hit) ?
                              etpbm_pkg::ST_MISS : etpbm_pkg::ST_OK;
      end
      etpbm_pkg::S_INSERT: begin
        if (full) rsp_q.status <= etpbm_pkg::ST_FULL;
      end
      etpbm_pkg::S_PORT: begin
        rsp_q.touched_port <= hit_attr.port;
        rsp_q.port_value   <= pval;
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("mapping count beyond table depth");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell matches the key");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("done strobe longer than one cycle or busy held after it");

  a_full_only_add: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == etpbm_pkg::ST_FULL) |-> is_add && full)
    else $error("full status on a request other than add");

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == etpbm_pkg::S_LOOKUP)
    else $error("accepted request did not enter lookup");

endmodule

// File: rtl/core/etpbm_cell.sv
`timescale 1ns / 1ps
// one slot of the sorted mapping row, shifts left on drop and right on insert
module etpbm_cell #(
  parameter int IDX         = 0,
  parameter int DEVICE_BITS = 16,
  parameter int CW          = 6
) (
  input  logic                   clk,
  input  etpbm_pkg::cell_cmd_t   cmd,
  input  logic [DEVICE_BITS-1:0] key,
  input  etpbm_pkg::attr_t       new_attr,
  input  logic [CW-1:0]          count,
  input  logic [DEVICE_BITS-1:0] left_dev,
  input  etpbm_pkg::attr_t       left_attr,
  input  logic                   left_slot,
  input  logic [DEVICE_BITS-1:0] right_dev,
  input  etpbm_pkg::attr_t       right_attr,
  output logic [DEVICE_BITS-1:0] dev,
  output etpbm_pkg::attr_t       attr,
  output logic                   hit,
  output logic                   slot
);

  logic occ;
  logic ge;

  always_comb begin
    occ  = count > CW'(IDX);
    hit  = occ && (dev == key);
    // the row is sorted, so key-or-above cells form the tail of the used part
    ge   = occ && !(dev < key);
    slot = ge || (count == CW'(IDX));
  end

  always_ff @(posedge clk) begin
    if (cmd.drop && ge) begin
      dev  <= right_dev;
      attr <= right_attr;
    end else if (cmd.insert && slot) begin
      if (left_slot) begin
        dev  <= left_dev;
        attr <= left_attr;
      end else begin
        dev  <= key;
        attr <= new_attr;
      end
    end
  end

endmodule
